/* design/jdht_pkg.sv */
// shared types and constants for the dht canonical huffman code builder
`default_nettype none

package jdht_pkg;

   // parse phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LENLO  = 3'd1;
   localparam logic [2:0] PH_CLASS  = 3'd2;
   localparam logic [2:0] PH_COUNTS = 3'd3;
   localparam logic [2:0] PH_VALUES = 3'd4;

   // register map
   localparam logic REG_TABLE_LIMIT = 1'b0;

   localparam logic [4:0]  TABLE_LIMIT_RESET = 5'd4;
   localparam logic [11:0] MAX_CODES         = 12'd256;
   localparam int          NUM_LENGTHS       = 16;

   typedef struct packed {
      logic        table_class;
      logic [3:0]  table_id;
      logic [4:0]  code_length;
      logic [15:0] code;
      logic [7:0]  symbol;
      logic [11:0] entry_index;
      logic        last_of_table;
      logic        last_of_segment;
      logic        bad_table;
   } rsp_type;

endpackage

`default_nettype wire

/* design/jpeg_dht_huffman_code_builder_top.sv */
// top level of the dht segment parser and canonical huffman code builder
`default_nettype none

// channel   | direction | ports                                   | transfer when
// ----------+-----------+-----------------------------------------+------------------------
// req       | in        | req_data_byte, req_segment_start        | req_valid & req_ready
// rsp       | out       | rsp_table_class ... rsp_bad_table       | rsp_valid & rsp_ready
// csr       | in/out    | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite
//
// one byte is taken per cycle while req_ready is high; header bytes produce nothing,
// each value byte produces one entry, registered into the output register or the skid entry
// the next-length search, the code shift and the increments sit in one
// combinational stage between the parse state and the output register
// reset (synchronous, active high) returns the parser to idle and table_limit to 4
// an output register plus a one-entry skid keep req_ready high while a result
// waits; req_ready drops only while the skid entry is occupied
module jpeg_dht_huffman_code_builder_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_segment_start,
   // result channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_table_class,
   output logic [3:0]        rsp_table_id,
   output logic [4:0]        rsp_code_length,
   output logic [15:0]       rsp_code,
   output logic [7:0]        rsp_symbol,
   output logic [11:0]       rsp_entry_index,
   output logic              rsp_last_of_table,
   output logic              rsp_last_of_segment,
   output logic              rsp_bad_table,
   // configuration port
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import jdht_pkg::*;

   // configuration
   logic [4:0] table_limit_ff;
   logic       csr_write;

   // parse state
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [3:0]  count_pos_ff, count_pos_in;
   logic [11:0] total_ff, total_in;
   logic [4:0]  cur_len_ff, cur_len_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] code_ff, code_in;
   logic [11:0] entry_ff, entry_in;
   logic [4:0]  class_id_ff, class_id_in;

   // per-length counts, written in the counts phase before any read
   logic [7:0]  count_ff [NUM_LENGTHS];
   logic        count_we;

   // output register and skid entry
   rsp_type     out_ff, skid_ff, res;
   logic        out_valid_ff, skid_valid_ff;
   logic        res_valid;
   logic        accept;

   // datapath helpers
   logic [15:0] len_word;
   logic [15:0] remaining_dec;
   logic [11:0] total_sum;
   logic [NUM_LENGTHS-1:0] nonzero;
   logic [4:0]  pick_len;
   logic        pick_found;
   logic [4:0]  pick_m1;
   logic [4:0]  eff_len;
   logic [7:0]  eff_left;
   logic [15:0] eff_code;
   logic [4:0]  shift_amt;
   logic [12:0] entry_next;
   logic        last_tab;
   logic        bad;

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_limit_ff <= TABLE_LIMIT_RESET;
      end else if (csr_write && (paddr[2] == REG_TABLE_LIMIT)) begin
         table_limit_ff <= pwdata[4:0];
      end
   end

   always_comb begin
      if (paddr[2] == REG_TABLE_LIMIT) begin
         prdata = {27'd0, table_limit_ff};
      end else begin
         prdata = 32'd0;
      end
   end

   // ------------------------------------------------------------------
   // handshake: stall only when the skid entry is full
   // ------------------------------------------------------------------
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // next-length search for the values phase
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < NUM_LENGTHS; i++) begin
         nonzero[i] = (count_ff[i] != 8'd0);
      end
      // lowest length above the current one with codes left
      pick_len   = 5'd16;
      pick_found = 1'b0;
      for (int j = NUM_LENGTHS; j >= 1; j--) begin
         if ((5'(j) > cur_len_ff) && nonzero[j-1]) begin
            pick_len   = 5'(j);
            pick_found = 1'b1;
         end
      end
      pick_m1 = pick_len - 5'd1;

      if (left_ff != 8'd0) begin
         eff_len   = cur_len_ff;
         eff_left  = left_ff;
         shift_amt = 5'd0;
      end else begin
         eff_len   = pick_len;
         eff_left  = pick_found ? count_ff[pick_m1[3:0]] : 8'd0;
         shift_amt = pick_len - cur_len_ff;
      end
      eff_code = code_ff << shift_amt[3:0];
   end

   // ------------------------------------------------------------------
   // parse step
   // ------------------------------------------------------------------
   assign len_word      = {len_high_ff, req_data_byte};
   assign remaining_dec = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : 16'd0;
   assign total_sum     = total_ff + {4'd0, req_data_byte};
   assign entry_next    = {1'b0, entry_ff} + 13'd1;
   assign last_tab      = entry_next >= {1'b0, total_ff};
   assign bad           = ({1'b0, class_id_ff[3:0]} >= table_limit_ff) ||
                          (total_ff > MAX_CODES);

   always_comb begin
      phase_in     = phase_ff;
      len_high_in  = len_high_ff;
      remaining_in = remaining_ff;
      count_pos_in = count_pos_ff;
      total_in     = total_ff;
      cur_len_in   = cur_len_ff;
      left_in      = left_ff;
      code_in      = code_ff;
      entry_in     = entry_ff;
      class_id_in  = class_id_ff;
      count_we     = 1'b0;
      res_valid    = 1'b0;

      res.table_class     = class_id_ff[4];
      res.table_id        = class_id_ff[3:0];
      res.code_length     = eff_len;
      res.code            = eff_code;
      res.symbol          = req_data_byte;
      res.entry_index     = entry_ff;
      res.last_of_table   = last_tab;
      res.last_of_segment = last_tab && (remaining_dec == 16'd0);
      res.bad_table       = bad;

      if (req_segment_start) begin
         // a start byte always opens a new segment
         len_high_in = req_data_byte;
         phase_in    = PH_LENLO;
      end else begin
         case (phase_ff)
            PH_LENLO: begin
               if (len_word <= 16'd2) begin
                  remaining_in = 16'd0;
                  phase_in     = PH_IDLE;
               end else begin
                  remaining_in = len_word - 16'd2;
                  phase_in     = PH_CLASS;
               end
            end
            PH_CLASS: begin
               class_id_in  = {(req_data_byte[7:4] != 4'd0), req_data_byte[3:0]};
               remaining_in = remaining_dec;
               count_pos_in = 4'd0;
               total_in     = 12'd0;
               phase_in     = PH_COUNTS;
            end
            PH_COUNTS: begin
               count_we     = 1'b1;
               total_in     = total_sum;
               remaining_in = remaining_dec;
               if (count_pos_ff == 4'd15) begin
                  count_pos_in = 4'd0;
                  if (total_sum == 12'd0) begin
                     // empty table
                     phase_in = (remaining_dec == 16'd0) ? PH_IDLE : PH_CLASS;
                  end else begin
                     cur_len_in = 5'd1;
                     left_in    = count_ff[0];
                     code_in    = 16'd0;
                     entry_in   = 12'd0;
                     phase_in   = PH_VALUES;
                  end
               end else begin
                  count_pos_in = count_pos_ff + 4'd1;
               end
            end
            PH_VALUES: begin
               res_valid    = 1'b1;
               remaining_in = remaining_dec;
               cur_len_in   = eff_len;
               code_in      = eff_code + 16'd1;
               left_in      = (eff_left != 8'd0) ? eff_left - 8'd1 : 8'd0;
               entry_in     = entry_next[11:0];
               if (last_tab) begin
                  phase_in = (remaining_dec == 16'd0) ? PH_IDLE : PH_CLASS;
               end
            end
            default: begin
               // idle bytes are dropped
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         len_high_ff  <= 8'd0;
         remaining_ff <= 16'd0;
         count_pos_ff <= 4'd0;
         total_ff     <= 12'd0;
         cur_len_ff   <= 5'd1;
         left_ff      <= 8'd0;
         code_ff      <= 16'd0;
         entry_ff     <= 12'd0;
         class_id_ff  <= 5'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         len_high_ff  <= len_high_in;
         remaining_ff <= remaining_in;
         count_pos_ff <= count_pos_in;
         total_ff     <= total_in;
         cur_len_ff   <= cur_len_in;
         left_ff      <= left_in;
         code_ff      <= code_in;
         entry_ff     <= entry_in;
         class_id_ff  <= class_id_in;
      end
   end

   // count store, no reset: every entry is written before a table reads it
   always_ff @(posedge clock) begin
      if (accept && count_we) begin
         count_ff[count_pos_ff] <= req_data_byte;
      end
   end

   // ------------------------------------------------------------------
   // output register and skid entry
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept && res_valid;
         end
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else begin
            out_ff <= res;
         end
      end else if (accept && res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_table_class     = out_ff.table_class;
   assign rsp_table_id        = out_ff.table_id;
   assign rsp_code_length     = out_ff.code_length;
   assign rsp_code            = out_ff.code;
   assign rsp_symbol          = out_ff.symbol;
   assign rsp_entry_index     = out_ff.entry_index;
   assign rsp_last_of_table   = out_ff.last_of_table;
   assign rsp_last_of_segment = out_ff.last_of_segment;
   assign rsp_bad_table       = out_ff.bad_table;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // the skid entry only fills behind a stalled output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a valid output register");

   // results only come from value bytes
   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid) |-> (phase_ff == PH_VALUES) && !req_segment_start)
      else $error("result produced outside the values phase");

   // a table in the values phase always has codes
   a_values_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUES) |-> (total_ff != 12'd0))
      else $error("values phase entered with an empty table");

   // end of segment is always also end of table
   a_seg_implies_tab: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_ff.last_of_segment || out_ff.last_of_table))
      else $error("last of segment flagged without last of table");

endmodule

`default_nettype wire
